@@ design/asm_pkg.sv @@
// Package for the automaton string matcher: shared widths, register indexes,
// controller state type and the controller-to-datapath command struct.
// No dependencies.
`timescale 1ns / 1ps

package asm_pkg;

    localparam int BYTE_W    = 8;
    localparam int PLEN_W    = 5;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int SHIFT_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } t_state;

    typedef struct packed {
        logic take;
        logic load;
    } t_dp_cmd;

endpackage

@@ design/asm_ctrl.sv @@
// Controller of the automaton string matcher: transaction sequencing and
// output-valid tracking. Depends on asm_pkg.
`timescale 1ns / 1ps

module asm_ctrl
    import asm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_settle;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !r_settle) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = r_settle;
                o_cmd.take = i_in_valid && !r_settle;
            end
            ST_EVAL: begin
                o_cmd.load = w_out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign n_out_valid = o_cmd.load || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_settle    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_settle    <= i_cfg_we;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ design/asm_datapath.sv @@
// Datapath of the automaton string matcher: pattern registers, prefix-suffix
// matrix, automaton state, byte count and result register. Depends on asm_pkg.
`timescale 1ns / 1ps

module asm_datapath
    import asm_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_dp_cmd              i_cmd,
    input  logic [BYTE_W-1:0]    i_text_byte,
    output logic                 o_match_found,
    output logic [SHIFT_W-1:0]   o_match_shift,
    output logic [PLEN_W-1:0]    o_matched_prefix
);

    localparam int NP   = MAX_PATTERN;
    localparam int QI_W = $clog2(NP + 1);
    localparam int WX   = (COUNT_WIDTH > SHIFT_W) ? COUNT_WIDTH : SHIFT_W;

    logic [CFG_W-1:0]       r_pat_low;
    logic [CFG_W-1:0]       r_pat_high;
    logic [PLEN_W-1:0]      r_plen;
    logic [BYTE_W-1:0]      w_pat [NP];
    logic [PLEN_W-1:0]      w_m;
    logic [NP:0][NP-1:0]    w_sfx;
    logic [NP:0][NP-1:0]    r_sfx;
    logic [NP-1:0]          w_row;
    logic [PLEN_W-1:0]      r_prefix;
    logic [PLEN_W-1:0]      r_q;
    logic [BYTE_W-1:0]      r_c;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [PLEN_W-1:0]      w_q_next;
    logic                   w_found;
    logic [COUNT_WIDTH-1:0] w_m_ext;
    logic [COUNT_WIDTH-1:0] w_diff;
    logic [SHIFT_W-1:0]     w_shift;
    logic                   r_found;
    logic [SHIFT_W-1:0]     r_shift;
    logic [PLEN_W-1:0]      r_qout;

    always_comb begin
        for (int i = 0; i < NP; i++) begin
            if (i < 8) begin
                w_pat[i] = r_pat_low[8*(i%8) +: BYTE_W];
            end else begin
                w_pat[i] = r_pat_high[8*(i%8) +: BYTE_W];
            end
        end
    end

    assign w_m = (r_plen > PLEN_W'(NP)) ? PLEN_W'(NP) : r_plen;

    // Entry [q][j] is set when the first j pattern bytes end the first q bytes.
    always_comb begin
        for (int q = 0; q <= NP; q++) begin
            for (int j = 0; j < NP; j++) begin
                w_sfx[q][j] = (j <= q);
                for (int i = 0; i < NP; i++) begin
                    if ((j <= q) && (i < j)) begin
                        w_sfx[q][j] = w_sfx[q][j] && (w_pat[i] == w_pat[(q - j + i) % NP]);
                    end
                end
            end
        end
    end

    assign w_row = r_sfx[r_q[QI_W-1:0]];

    always_comb begin
        w_q_next = '0;
        for (int k = 1; k <= NP; k++) begin
            if ((PLEN_W'(k) <= w_m) && (PLEN_W'(k) <= r_q + PLEN_W'(1))
                && w_row[k-1] && (w_pat[k-1] == r_c)) begin
                w_q_next = PLEN_W'(k);
            end
        end
    end

    assign w_found = (w_q_next == w_m);
    assign w_m_ext = COUNT_WIDTH'(w_m);
    assign w_diff  = (w_found && (r_count >= w_m_ext)) ? (r_count - w_m_ext) : '0;
    assign w_shift = SHIFT_W'(WX'(w_diff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_plen     <= '0;
            r_prefix   <= '0;
            r_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PATTERN_LOW:    r_pat_low  <= i_cfg_data;
                    REG_PATTERN_HIGH:   r_pat_high <= i_cfg_data;
                    REG_PATTERN_LENGTH: r_plen     <= i_cfg_data[PLEN_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.take && (r_count != '1)) begin
                r_count <= r_count + COUNT_WIDTH'(1);
            end
            if (i_cmd.load) begin
                r_prefix <= w_q_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sfx <= w_sfx;
        if (i_cmd.take) begin
            r_c <= i_text_byte;
            r_q <= (r_prefix > w_m) ? w_m : r_prefix;
        end
        if (i_cmd.load) begin
            r_found <= w_found;
            r_shift <= w_shift[SHIFT_W-1:0];
            r_qout  <= w_q_next;
        end
    end

    assign o_match_found    = r_found;
    assign o_match_shift    = r_shift;
    assign o_matched_prefix = r_qout;

endmodule

@@ design/automaton_string_matcher.sv @@
// Top level of the automaton string matcher: controller, datapath and checks.
// Depends on asm_pkg, asm_ctrl and asm_datapath.
//
// Text bytes enter on the input channel (i_in_valid, o_in_stall, i_text_byte)
// and one result leaves per byte on the output channel (o_out_valid,
// i_out_stall, o_match_found, o_match_shift, o_matched_prefix).
// A transaction is accepted at a clock edge where valid is high and stall low.
// No new byte is taken until the last byte's result is registered. Idle latches
// the byte; evaluation selects a row of the registered prefix-suffix matrix
// and picks the next state. The output register holds a result while the
// receiver stalls; the next byte is still taken and its result waits in
// evaluation until the register frees. The user writes the pattern through
// i_cfg_we, i_cfg_index and i_cfg_data only while the block is idle; the block
// does not enforce this. The input stalls in the cycle after each write while
// the matrix is rebuilt. A synchronous reset clears the pattern, the
// automaton state and the byte count, and leaves no result pending.
`timescale 1ns / 1ps

module automaton_string_matcher
    import asm_pkg::*;
#(
    parameter int MAX_PATTERN = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_text_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_match_found,
    output logic [SHIFT_W-1:0]   o_match_shift,
    output logic [PLEN_W-1:0]    o_matched_prefix
);

    t_dp_cmd w_cmd;

    asm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    asm_datapath #(
        .MAX_PATTERN (MAX_PATTERN),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (w_cmd),
        .i_text_byte      (i_text_byte),
        .o_match_found    (o_match_found),
        .o_match_shift    (o_match_shift),
        .o_matched_prefix (o_matched_prefix)
    );

`ifndef SYNTH
    a_prefix_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_matched_prefix <= PLEN_W'(MAX_PATTERN)))
        else $error("Matched prefix exceeds the maximum pattern length.");

    a_shift_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_match_found) |-> (o_match_shift == '0))
        else $error("Shift is nonzero without a match.");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("A byte was taken while another was being evaluated.");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> o_out_valid)
        else $error("A computed result was not presented.");
`endif

endmodule
